FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define MKDEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define MKDEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/mkdel_pkg.sv
// Types and constants of the key debouncer with change events
package mkdel_pkg;

  localparam int unsigned RawW    = 4;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CountW  = 8;

  localparam logic [CountW-1:0] COUNT_MAX   = 8'd255;
  localparam logic [CountW-1:0] LIMIT_RESET = 8'd5;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_INVALID   = 2'd0,
    STATUS_UNCHANGED = 2'd1,
    STATUS_CHANGED   = 2'd2
  } status_e;

  typedef struct packed {
    logic tick;
    logic sample;
    logic mark_read;
  } key_ctrl_t;

  typedef struct packed {
    logic    level;
    status_e status;
  } key_view_t;

endpackage

FILE: hw/rtl/mkdel_in_if.sv
// Input channel: tick or read transaction with valid/ready handshake
interface mkdel_in_if;
  import mkdel_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [RawW-1:0]     raw_keys;
  logic [IdxW-1:0]     key_index;

  modport source (output valid, output kind, output raw_keys, output key_index,
                  input ready);
  modport sink   (input valid, input kind, input raw_keys, input key_index,
                  output ready);
endinterface

FILE: hw/rtl/mkdel_out_if.sv
// Output channel: key level and change status with valid/ready handshake
interface mkdel_out_if;
  logic       valid;
  logic       ready;
  logic       key_level;
  logic [1:0] change_status;

  modport source (output valid, output key_level, output change_status,
                  input ready);
  modport sink   (input valid, input key_level, input change_status,
                  output ready);
endinterface

FILE: hw/rtl/mkdel_key_cell.sv
// Per-key settle counter, candidate and stable level, event status and read mark
module mkdel_key_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [mkdel_pkg::CountW-1:0]          limit_i,
  input  mkdel_pkg::key_ctrl_t                  ctrl_i,
  output mkdel_pkg::key_view_t                  view_o
);
  import mkdel_pkg::*;

  logic              stable_q, stable_d;
  logic              cand_q, cand_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  status_e           status_q, status_d;
  logic              read_q, read_d;

  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    read_d   = read_q;
    if (ctrl_i.tick) begin
      priority if (ctrl_i.sample != cand_q) begin
        cnt_d  = '0;
        cand_d = ctrl_i.sample;
        if (read_q) status_d = STATUS_UNCHANGED;
      end else if (cnt_q == limit_i) begin
        stable_d = ctrl_i.sample;
        status_d = STATUS_CHANGED;
        read_d   = 1'b0;
        if (cnt_q != COUNT_MAX) cnt_d = cnt_q + 8'd1;
      end else if ((cnt_q > limit_i) && read_q) begin
        status_d = STATUS_UNCHANGED;
      end else if (cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + 8'd1;
      end else begin
        cnt_d = cnt_q;
      end
    end else if (ctrl_i.mark_read) begin
      read_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      cand_q   <= 1'b0;
      cnt_q    <= '0;
      status_q <= STATUS_INVALID;
      read_q   <= 1'b1;
    end else begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      read_q   <= read_d;
    end
  end

  assign view_o.level  = stable_q;
  assign view_o.status = status_q;

endmodule

FILE: hw/rtl/multi_key_debounce_event_latch.sv
// A read transaction's result passes through the input register and then the result register.
// One transaction per cycle unless a result is stalled; ticks and reads may follow back to back.
// The input register advances whenever the result register is empty or being taken.
// Reset: all keys released, counters zero, status invalid, marked read; limit set to 5.
// Ticks produce no result; reads return the key level and change status.
`include "assert_macros.svh"

module multi_key_debounce_event_latch #(
  parameter int unsigned KEY_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mkdel_pkg::CountW-1:0]  cfg_wdata_i,
  mkdel_in_if.sink                      in_i,
  mkdel_out_if.source                   out_o
);
  import mkdel_pkg::*;

  localparam int unsigned KeyW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic [CountW-1:0] limit_q;
  logic              in_valid_q;
  kind_e             kind_q;
  logic [RawW-1:0]   raw_q;
  logic [IdxW-1:0]   idx_q;
  logic              out_valid_q, out_valid_d;
  logic              level_q;
  status_e           status_q;

  logic              out_free;
  logic              stage_go;
  logic              in_range;
  logic [KeyW-1:0]   sel;
  key_ctrl_t         key_ctrl [KEY_COUNT];
  key_view_t         key_view [KEY_COUNT];

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || out_free;
  assign stage_go = in_valid_q && out_free;

  assign in_range = (32'(idx_q) < KEY_COUNT);
  assign sel = in_range ? KeyW'(idx_q) : KeyW'(KEY_COUNT - 1);

  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_key
    if (g < RawW) begin : g_raw
      assign key_ctrl[g].sample = raw_q[g];
    end else begin : g_none
      assign key_ctrl[g].sample = 1'b0;
    end
    assign key_ctrl[g].tick      = stage_go && (kind_q == KIND_TICK);
    assign key_ctrl[g].mark_read = stage_go && (kind_q == KIND_READ) && in_range &&
                                   (sel == KeyW'(g));

    mkdel_key_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .limit_i (limit_q),
      .ctrl_i  (key_ctrl[g]),
      .view_o  (key_view[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      kind_q <= kind_e'(in_i.kind);
      raw_q  <= in_i.raw_keys;
      idx_q  <= in_i.key_index;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = stage_go && (kind_q == KIND_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && (kind_q == KIND_READ)) begin
      level_q  <= key_view[sel].level;
      status_q <= key_view[sel].status;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.key_level     = level_q;
  assign out_o.change_status = status_q;

  `MKDEL_ASSERT_IMP(a_stall_only_on_full, !in_i.ready, out_valid_q && !out_o.ready)
  `MKDEL_ASSERT_NEXT(a_tick_no_result, stage_go && (kind_q == KIND_TICK), !out_valid_q)
  `MKDEL_ASSERT_IMP(a_result_from_read, $rose(out_valid_q),
                    $past(stage_go && (kind_q == KIND_READ)))

endmodule

FILE: tb/sv/tb.sv
// Testbench for the four-key debouncer: directed and random transactions checked against a predictor
`timescale 1ns / 100ps

module tb;
  import mkdel_pkg::*;

  localparam int unsigned KEY_COUNT = 4;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  mkdel_in_if  in_if ();
  mkdel_out_if out_if ();

  multi_key_debounce_event_latch #(
    .KEY_COUNT (KEY_COUNT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic              stable_q    [KEY_COUNT];
  logic              candidate_q [KEY_COUNT];
  logic [CountW-1:0] settle_q    [KEY_COUNT];
  status_e           status_q    [KEY_COUNT];
  logic              acked_q     [KEY_COUNT];
  logic [CountW-1:0] limit_q;

  key_view_t   expected_views [$];
  int unsigned error_count;
  int unsigned burst_left;
  bit          tx_idle_en;
  bit          rx_stall_en;
  logic [7:0]  stall_pattern;

  function automatic void reset_keys();
    limit_q = LIMIT_RESET;
    for (int k = 0; k < KEY_COUNT; k++) begin
      stable_q[k]    = 1'b0;
      candidate_q[k] = 1'b0;
      settle_q[k]    = '0;
      status_q[k]    = STATUS_INVALID;
      acked_q[k]     = 1'b1;
    end
  endfunction

  function automatic void apply_tick(logic [RawW-1:0] raw);
    logic sample;
    for (int k = 0; k < KEY_COUNT; k++) begin
      sample = (k < RawW) ? raw[k] : 1'b0;
      if (sample != candidate_q[k]) begin
        settle_q[k]    = '0;
        candidate_q[k] = sample;
        if (acked_q[k]) status_q[k] = STATUS_UNCHANGED;
      end else if (settle_q[k] == limit_q) begin
        stable_q[k] = sample;
        status_q[k] = STATUS_CHANGED;
        acked_q[k]  = 1'b0;
        if (settle_q[k] != COUNT_MAX) settle_q[k] = settle_q[k] + 1'b1;
      end else if (settle_q[k] > limit_q && acked_q[k]) begin
        status_q[k] = STATUS_UNCHANGED;
      end else if (settle_q[k] != COUNT_MAX) begin
        settle_q[k] = settle_q[k] + 1'b1;
      end
    end
  endfunction

  function automatic void read_key(logic [IdxW-1:0] idx);
    int unsigned k;
    key_view_t   view;
    if (idx < KEY_COUNT) begin
      k = idx;
      acked_q[k] = 1'b1;
    end else begin
      k = KEY_COUNT - 1;
    end
    view.level  = stable_q[k];
    view.status = status_q[k];
    expected_views.push_back(view);
  endfunction

  function automatic logic [IdxW-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return IdxW'($urandom_range(0, KEY_COUNT - 1));
    return IdxW'($urandom_range(KEY_COUNT, 7));
  endfunction

  task automatic send_item(kind_e kind, logic [RawW-1:0] raw, logic [IdxW-1:0] idx);
    if (tx_idle_en) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.raw_keys  <= raw;
    in_if.key_index <= idx;
    do @(posedge clk_i); while (!in_if.ready);
    if (kind == KIND_TICK) apply_tick(raw);
    else read_key(idx);
  endtask

  task automatic send_tick(logic [RawW-1:0] raw);
    send_item(KIND_TICK, raw, IdxW'($urandom_range(0, 7)));
  endtask

  task automatic send_read(logic [IdxW-1:0] idx);
    send_item(KIND_READ, RawW'($urandom_range(0, 15)), idx);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CountW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    limit_q = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_after_reset();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (int i = 0; i < 8; i++) send_read(IdxW'(i));
  endtask

  task automatic test_restart_from_invalid();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    send_tick(4'b0101);
    for (int i = 0; i < KEY_COUNT; i++) send_read(IdxW'(i));
  endtask

  task automatic test_latch_and_ack();
    repeat (6) send_tick(4'b0101);
    send_read(3'd7);
    send_read(3'd0);
    send_read(3'd3);
    send_tick(4'b0101);
    send_read(3'd0);
    send_read(3'd4);
  endtask

  task automatic test_counter_top();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b1;
    write_limit(8'd0);
    for (int i = 0; i < 40; i++) begin
      send_tick(4'b1111);
      if (i % 8 == 0) send_read(pick_key());
    end
    for (int i = 0; i < KEY_COUNT; i++) send_read(IdxW'(i));
    write_limit(8'd254);
    for (int i = 0; i < 262; i++) begin
      send_tick(4'b0000);
      if (i >= 252 && i <= 256) send_read(IdxW'(i % KEY_COUNT));
    end
    write_limit(COUNT_MAX);
    for (int i = 0; i < 270; i++) begin
      send_tick(4'b1010);
      if (i % 50 == 0 || i > 255) send_read(pick_key());
    end
  endtask

  task automatic run_random_phase(int unsigned items, logic [CountW-1:0] lim);
    int unsigned sent;
    int unsigned len;
    logic [RawW-1:0] level;
    sent = 0;
    write_limit(lim);
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        level = RawW'($urandom_range(0, 15));
        repeat ($urandom_range(0, 2)) begin
          send_tick(RawW'($urandom_range(0, 15)));
          sent++;
        end
        len = lim + $urandom_range(0, 3);
        for (int j = 0; j < len; j++) begin
          send_tick(level);
          sent++;
          if ($urandom_range(0, 7) == 0) begin
            send_read(pick_key());
            sent++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          send_read(pick_key());
          sent++;
        end
      end else begin
        if ($urandom_range(0, 1) == 1) send_tick(RawW'($urandom_range(0, 15)));
        else send_read(pick_key());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CountW-1:0] lim;
    for (int p = 0; p < 6; p++) begin
      tx_idle_en  = (p % 3) != 2;
      rx_stall_en = (p % 3) != 1 && (p % 3) != 2;
      case (p)
        0: lim = 8'd0;
        1: lim = 8'd1;
        2: lim = CountW'($urandom_range(2, 3));
        3: lim = LIMIT_RESET;
        default: lim = CountW'($urandom_range(0, 12));
      endcase
      run_random_phase(45, lim);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready  <= 1'b0;
    stall_pattern = 8'h5b;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 31) == 0) stall_pattern = 8'($urandom()) | 8'h01;
      else stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      out_if.ready <= rx_stall_en ? stall_pattern[0] : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    key_view_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_views.size() == 0) begin
        $error("result transaction with none expected: key_level %0d change_status %0d",
               out_if.key_level, out_if.change_status);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        if (out_if.key_level !== want.level) begin
          $error("key_level mismatch: expected %0d, actual %0d", want.level, out_if.key_level);
          error_count++;
        end
        if (out_if.change_status !== want.status) begin
          $error("change_status mismatch: expected %0d, actual %0d",
                 want.status, out_if.change_status);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    error_count = 0;
    burst_left  = 0;
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    reset_keys();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_TICK;
    in_if.raw_keys  <= '0;
    in_if.key_index <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_restart_from_invalid();
    test_latch_and_ack();
    test_counter_top();
    test_random_traffic();
    drain_results();
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
